### hw/rtl/dcpr_pkg.sv
// shared types and constants for the dithered column page rasterizer
`timescale 1ns / 1ps

package dcpr_pkg;

  localparam int DEF_MAX_PAGES = 8;

  localparam int HEIGHT_W    = 12;
  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 3;
  localparam int SP_W        = 4;
  localparam int TABLE_W     = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 1;
  localparam int Q5_W        = 13;
  localparam int ROW_W       = 8;
  localparam int ROT_W       = 3;
  localparam int LEVELS      = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_PAGES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DITHER_TABLE = 1'd1;

  localparam logic [SP_W-1:0]  SP_RESET = 4'd8;
  localparam logic [ROT_W-1:0] ROT_STEP = 3'd5;
  localparam logic [Q5_W-1:0]  ROUND_HALF = 13'd16;

  typedef struct packed {
    logic load;
    logic prep;
    logic emit;
  } dcpr_cmd_t;

  typedef struct packed {
    logic last;
  } dcpr_stat_t;

endpackage

### hw/rtl/dithered_column_page_rasterizer.sv
// order: the column is accepted, its span and dither are set up, then its page bytes
// are emitted, one page byte per cycle while the output is not stalled by out_ready
// the next column is taken only once the last page byte has been registered
// reset: synchronous active low; screen_pages returns to 8, dither table and
// rotation to zero, output valid drops
`timescale 1ns / 1ps

module dithered_column_page_rasterizer
  import dcpr_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [HEIGHT_W-1:0]    in_column_height,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_W-1:0]      out_page_byte,
  output logic [INDEX_W-1:0]     out_page_index,
  output logic                   out_last_page
);

  dcpr_cmd_t  cmd;
  dcpr_stat_t stat;

  dcpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dcpr_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_column_height (in_column_height),
    .cmd              (cmd),
    .stat             (stat),
    .out_page_byte    (out_page_byte),
    .out_page_index   (out_page_index),
    .out_last_page    (out_last_page)
  );

endmodule

### hw/rtl/dcpr_ctrl.sv
// controller fsm: sequences accept, span setup and page emission
`timescale 1ns / 1ps

module dcpr_ctrl
  import dcpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dcpr_stat_t stat,
  output dcpr_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       push;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign push      = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.prep = (state_r == S_PREP);
    cmd.emit = push;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: state_nxt = S_EMIT;
      S_EMIT: begin
        if (push && stat.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (push) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_PREP))
    else $error("accepted transaction did not start span setup");

  a_prep_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |=> (state_r == S_EMIT))
    else $error("span setup not followed by page emission");

  a_no_extra_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_EMIT) && out_ready) |=> !out_valid_r)
    else $error("output valid raised outside page emission");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (push && stat.last) |=> (state_r == S_IDLE) && out_valid_r)
    else $error("last page did not return to idle");
`endif

endmodule

### hw/rtl/dcpr_datapath.sv
// datapath: config registers, span and dither setup, page byte generation
`timescale 1ns / 1ps

module dcpr_datapath
  import dcpr_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [HEIGHT_W-1:0]    in_column_height,
  input  dcpr_cmd_t              cmd,
  output dcpr_stat_t             stat,
  output logic [BYTE_W-1:0]      out_page_byte,
  output logic [INDEX_W-1:0]     out_page_index,
  output logic                   out_last_page
);

  localparam int CW = $clog2(MAX_PAGES + 1);

  logic [SP_W-1:0]     sp_r;
  logic [TABLE_W-1:0]  table_r;
  logic [ROT_W-1:0]    rot_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CW-1:0]       pages_r;
  logic [CW-1:0]       page_r;
  logic [ROW_W-1:0]    y1_r, y2_r;
  logic [BYTE_W-1:0]   dith_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [INDEX_W-1:0]  index_r;
  logic                last_r;

  logic [CW-1:0]        act_pages;
  logic [HEIGHT_W-1:0]  cap, clipped;
  logic [Q5_W-1:0]      y1q, y2q;
  logic [ROW_W-1:0]     y1, y2;
  logic [ROW_W-1:0]     n;
  logic [LEVELS-2:0]    ge;
  logic [ROT_W-1:0]     idx;
  logic [BYTE_W-1:0]    dsel;
  logic [2*BYTE_W-1:0]  d16;
  logic [BYTE_W-1:0]    lit;
  logic                 last;

  // clamp the page register to 1..MAX_PAGES
  always_comb begin
    if (sp_r == '0) act_pages = CW'(1);
    else if ({1'b0, sp_r} > (SP_W+1)'(MAX_PAGES)) act_pages = CW'(MAX_PAGES);
    else act_pages = CW'(sp_r);
  end

  // span in q.5: y1 = 16h - clipped, y2 = y1 + 2*clipped, rounded half up
  always_comb begin
    cap     = HEIGHT_W'({pages_r, 7'b0});
    clipped = (height_r <= cap) ? height_r : cap;
    y1q     = Q5_W'({pages_r, 7'b0}) - Q5_W'(clipped);
    y2q     = y1q + Q5_W'({clipped, 1'b0});
    y1      = ROW_W'((y1q + ROUND_HALF) >> 5);
    y2      = ROW_W'((y2q + ROUND_HALF) >> 5);
  end

  // dither level = min(7, floor((clipped/16) / pages)) as a count of thresholds
  always_comb begin
    n = ROW_W'(clipped >> 4);
    for (int k = 1; k < LEVELS; k++) begin
      ge[k-1] = (n >= ROW_W'((CW+3)'(k) * (CW+3)'(pages_r)));
    end
    idx  = ROT_W'($countones(ge));
    dsel = table_r[idx*BYTE_W +: BYTE_W];
    d16  = {dsel, dsel} >> rot_r;
  end

  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      lit[i] = (ROW_W'({page_r, 3'(i)}) >= y1_r) && (ROW_W'({page_r, 3'(i)}) < y2_r);
    end
    last = (CW'(page_r + 1'b1) == pages_r);
  end

  assign stat.last      = last;
  assign out_page_byte  = byte_r;
  assign out_page_index = index_r;
  assign out_last_page  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= SP_RESET;
      table_r <= '0;
      rot_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCREEN_PAGES: sp_r    <= cfg_data[SP_W-1:0];
          REG_DITHER_TABLE: table_r <= cfg_data[TABLE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.prep) rot_r <= rot_r + ROT_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      height_r <= in_column_height;
      pages_r  <= act_pages;
    end
    if (cmd.prep) begin
      y1_r   <= y1;
      y2_r   <= y2;
      dith_r <= d16[BYTE_W-1:0];
      page_r <= '0;
    end
    if (cmd.emit) begin
      byte_r  <= lit & dith_r;
      index_r <= INDEX_W'(page_r);
      last_r  <= last;
      page_r  <= CW'(page_r + 1'b1);
    end
  end

endmodule
